[hw/rtl/lhs_pkg.sv]
// Shared widths, register indexes and a helper for the Lorenz Heun step block.
package lhs_pkg;

  localparam int FRAC_BITS_DEFAULT = 24;
  localparam int COORD_W           = 32;
  localparam int COEF_W            = 31;
  localparam int STEP_W            = 25;
  localparam int CFG_INDEX_W       = 2;
  localparam int CFG_DATA_W        = COEF_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SIGMA = 2'd0,
    CFG_RHO   = 2'd1,
    CFG_BETA  = 2'd2,
    CFG_STEP  = 2'd3
  } cfg_index_t;

  // Coefficient reset values clip to the largest 31-bit value.
  function automatic logic [COEF_W-1:0] sat_coef(input logic [63:0] v);
    logic [63:0] lim;
    lim = (64'd1 << COEF_W) - 64'd1;
    return (v > lim) ? lim[COEF_W-1:0] : v[COEF_W-1:0];
  endfunction

endpackage

[hw/rtl/lhs_item_if.sv]
// Input channel: command and point to load.
interface lhs_item_if
  import lhs_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [COORD_W-1:0] load_x;
  logic signed [COORD_W-1:0] load_y;
  logic signed [COORD_W-1:0] load_z;

  modport source (output valid, cmd, load_x, load_y, load_z, input ready);
  modport sink   (input valid, cmd, load_x, load_y, load_z, output ready);
endinterface

[hw/rtl/lhs_result_if.sv]
// Result channel: point after each transaction and the clamp flag.
interface lhs_result_if
  import lhs_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic                      saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

[hw/rtl/lorenz_heun_step.sv]
// Lorenz system integrator: loads a point, or advances it by one Heun step on a shared multiplier.
//
// item carries a command: cmd 0 loads (load_x, load_y, load_z) into the
// held point, cmd 1 advances the point by one Heun step using sigma, rho,
// beta and dt from the configuration port. Every transaction returns one
// result on result: the point held afterwards and a flag that is set when
// any derivative, predictor or new coordinate was clamped to 32 bits.
// Coordinates and coefficients are fixed point with FRAC_BITS fraction bits.
// A step issues fourteen products to one 33x33 multiplier; operand select,
// multiply and round/accumulate are three register stages,
// and dependent products wait for the previous result to leave the last one.
// item.ready is high only while no transaction is in progress, so a new
// transaction is accepted only after the previous result is registered.
// A finished result waits in the output register while the next transaction
// is accepted and computed; a stalled receiver only holds the block when the
// next result is ready to be written.
// Reset clears the point to zero, restores the default coefficients and
// empties the output register.
module lorenz_heun_step
  import lhs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  lhs_item_if.sink               item,
  lhs_result_if.source           result
);

  localparam int OPND_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * OPND_W;
  localparam int EXT_W    = PROD_W + 1;
  localparam int SD_W     = EXT_W - FRAC_BITS;
  localparam int SUM_W    = SD_W + 1;
  localparam int CNT_W    = 5;
  localparam logic [CNT_W-1:0] LAST_CNT = 5'd16;

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
  localparam logic [COEF_W-1:0] SIGMA_RST = sat_coef(64'd10 * ONE);
  localparam logic [COEF_W-1:0] RHO_RST   = sat_coef(64'd28 * ONE);
  localparam logic [COEF_W-1:0] BETA_RST  = sat_coef((64'd16 * ONE + 64'd3) / 64'd6);
  localparam logic [STEP_W-1:0] STEP_RST  = STEP_W'((ONE + 64'd50) / 64'd100);

  localparam logic signed [EXT_W-1:0] HALF_N = EXT_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [EXT_W-1:0] HALF_F = EXT_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_S0, OP_R0, OP_XY0, OP_B0,
    OP_MX, OP_MY, OP_MZ,
    OP_S1, OP_R1, OP_XY1, OP_B1,
    OP_FX, OP_FY, OP_FZ
  } op_t;

  state_t     state;
  logic [CNT_W-1:0] count;
  op_t        issue_op, op1, op2;

  logic [COEF_W-1:0] sigma_coef, rho_coef, beta_coef;
  logic [STEP_W-1:0] time_step;

  logic signed [COORD_W-1:0] px, py, pz;
  logic signed [COORD_W-1:0] mx, my, mz;
  logic signed [COORD_W-1:0] f0x, f0y, f0z;
  logic signed [COORD_W-1:0] f1x, f1y, f1z;
  logic signed [SD_W-1:0]    tmp;
  logic                      sat;

  logic signed [OPND_W-1:0] opa_next, opb_next, opa, opb;
  logic signed [PROD_W-1:0] prod;

  logic signed [EXT_W-1:0]   prod_ext, sdn_full, sdf_full;
  logic signed [SD_W-1:0]    sdn, sdf;
  logic signed [SUM_W-1:0]   post_sum;
  logic [SUM_W-COORD_W:0]    post_top;
  logic                      post_clip;
  logic signed [COORD_W-1:0] post_val;

  logic                      rvalid, rsat;
  logic signed [COORD_W-1:0] rx, ry, rz;

  assign item.ready       = (state == ST_IDLE);
  assign result.valid     = rvalid;
  assign result.out_x     = rx;
  assign result.out_y     = ry;
  assign result.out_z     = rz;
  assign result.saturated = rsat;

  // Issue schedule; a product reaches its target through the operand, product and result registers.
  always_comb begin
    issue_op = OP_NOP;
    case (count)
      5'd0:    issue_op = OP_S0;
      5'd1:    issue_op = OP_R0;
      5'd2:    issue_op = OP_XY0;
      5'd3:    issue_op = OP_B0;
      5'd4:    issue_op = OP_MX;
      5'd5:    issue_op = OP_MY;
      5'd6:    issue_op = OP_MZ;
      5'd8:    issue_op = OP_S1;
      5'd9:    issue_op = OP_R1;
      5'd10:   issue_op = OP_XY1;
      5'd11:   issue_op = OP_B1;
      5'd12:   issue_op = OP_FX;
      5'd13:   issue_op = OP_FY;
      5'd14:   issue_op = OP_FZ;
      default: issue_op = OP_NOP;
    endcase
  end

  always_comb begin
    opa_next = '0;
    opb_next = '0;
    case (issue_op)
      OP_S0: begin
        opa_next = {2'b00, sigma_coef};
        opb_next = {py[COORD_W-1], py} - {px[COORD_W-1], px};
      end
      OP_R0: begin
        opa_next = {px[COORD_W-1], px};
        opb_next = {2'b00, rho_coef} - {pz[COORD_W-1], pz};
      end
      OP_XY0: begin
        opa_next = {px[COORD_W-1], px};
        opb_next = {py[COORD_W-1], py};
      end
      OP_B0: begin
        opa_next = {2'b00, beta_coef};
        opb_next = {pz[COORD_W-1], pz};
      end
      OP_MX: begin
        opa_next = {{(OPND_W-STEP_W){1'b0}}, time_step};
        opb_next = {f0x[COORD_W-1], f0x};
      end
      OP_MY: begin
        opa_next = {{(OPND_W-STEP_W){1'b0}}, time_step};
        opb_next = {f0y[COORD_W-1], f0y};
      end
      OP_MZ: begin
        opa_next = {{(OPND_W-STEP_W){1'b0}}, time_step};
        opb_next = {f0z[COORD_W-1], f0z};
      end
      OP_S1: begin
        opa_next = {2'b00, sigma_coef};
        opb_next = {my[COORD_W-1], my} - {mx[COORD_W-1], mx};
      end
      OP_R1: begin
        opa_next = {mx[COORD_W-1], mx};
        opb_next = {2'b00, rho_coef} - {mz[COORD_W-1], mz};
      end
      OP_XY1: begin
        opa_next = {mx[COORD_W-1], mx};
        opb_next = {my[COORD_W-1], my};
      end
      OP_B1: begin
        opa_next = {2'b00, beta_coef};
        opb_next = {mz[COORD_W-1], mz};
      end
      OP_FX: begin
        opa_next = {{(OPND_W-STEP_W){1'b0}}, time_step};
        opb_next = {f0x[COORD_W-1], f0x} + {f1x[COORD_W-1], f1x};
      end
      OP_FY: begin
        opa_next = {{(OPND_W-STEP_W){1'b0}}, time_step};
        opb_next = {f0y[COORD_W-1], f0y} + {f1y[COORD_W-1], f1y};
      end
      OP_FZ: begin
        opa_next = {{(OPND_W-STEP_W){1'b0}}, time_step};
        opb_next = {f0z[COORD_W-1], f0z} + {f1z[COORD_W-1], f1z};
      end
      default: begin
        opa_next = '0;
        opb_next = '0;
      end
    endcase
  end

  // Round half up, then floor; the final average uses one more bit of shift.
  assign prod_ext = {prod[PROD_W-1], prod};
  assign sdn_full = (prod_ext + HALF_N) >>> FRAC_BITS;
  assign sdf_full = (prod_ext + HALF_F) >>> (FRAC_BITS + 1);
  assign sdn      = sdn_full[SD_W-1:0];
  assign sdf      = sdf_full[SD_W-1:0];

  always_comb begin
    post_sum = '0;
    case (op2)
      OP_S0, OP_S1: post_sum = {sdn[SD_W-1], sdn};
      OP_R0: post_sum = {sdn[SD_W-1], sdn} - {{(SUM_W-COORD_W){py[COORD_W-1]}}, py};
      OP_R1: post_sum = {sdn[SD_W-1], sdn} - {{(SUM_W-COORD_W){my[COORD_W-1]}}, my};
      OP_B0, OP_B1: post_sum = {tmp[SD_W-1], tmp} - {sdn[SD_W-1], sdn};
      OP_MX: post_sum = {{(SUM_W-COORD_W){px[COORD_W-1]}}, px} + {sdn[SD_W-1], sdn};
      OP_MY: post_sum = {{(SUM_W-COORD_W){py[COORD_W-1]}}, py} + {sdn[SD_W-1], sdn};
      OP_MZ: post_sum = {{(SUM_W-COORD_W){pz[COORD_W-1]}}, pz} + {sdn[SD_W-1], sdn};
      OP_FX: post_sum = {{(SUM_W-COORD_W){px[COORD_W-1]}}, px} + {sdf[SD_W-1], sdf};
      OP_FY: post_sum = {{(SUM_W-COORD_W){py[COORD_W-1]}}, py} + {sdf[SD_W-1], sdf};
      OP_FZ: post_sum = {{(SUM_W-COORD_W){pz[COORD_W-1]}}, pz} + {sdf[SD_W-1], sdf};
      default: post_sum = '0;
    endcase
  end

  assign post_top  = post_sum[SUM_W-1:COORD_W-1];
  assign post_clip = !((&post_top) || !(|post_top));
  assign post_val  = post_clip ? {post_sum[SUM_W-1], {(COORD_W-1){~post_sum[SUM_W-1]}}}
                               : post_sum[COORD_W-1:0];

  always_ff @(posedge clk) begin
    opa  <= opa_next;
    opb  <= opb_next;
    prod <= opa * opb;
    case (op2)
      OP_S0:  f0x <= post_val;
      OP_R0:  f0y <= post_val;
      OP_B0:  f0z <= post_val;
      OP_MX:  mx  <= post_val;
      OP_MY:  my  <= post_val;
      OP_MZ:  mz  <= post_val;
      OP_S1:  f1x <= post_val;
      OP_R1:  f1y <= post_val;
      OP_B1:  f1z <= post_val;
      OP_XY0, OP_XY1: tmp <= sdn;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      op1        <= OP_NOP;
      op2        <= OP_NOP;
      rvalid     <= 1'b0;
      sat        <= 1'b0;
      px         <= '0;
      py         <= '0;
      pz         <= '0;
      sigma_coef <= SIGMA_RST;
      rho_coef   <= RHO_RST;
      beta_coef  <= BETA_RST;
      time_step  <= STEP_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SIGMA: sigma_coef <= cfg_data[COEF_W-1:0];
          CFG_RHO:   rho_coef   <= cfg_data[COEF_W-1:0];
          CFG_BETA:  beta_coef  <= cfg_data[COEF_W-1:0];
          CFG_STEP:  time_step  <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end

      op1 <= (state == ST_RUN) ? issue_op : OP_NOP;
      op2 <= op1;

      if (state == ST_FINISH && (!rvalid || result.ready)) begin
        rvalid <= 1'b1;
      end else if (result.ready) begin
        rvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (item.valid) begin
            sat   <= 1'b0;
            count <= '0;
            if (item.cmd) begin
              state <= ST_RUN;
            end else begin
              px    <= item.load_x;
              py    <= item.load_y;
              pz    <= item.load_z;
              state <= ST_FINISH;
            end
          end
        end
        ST_RUN: begin
          count <= count + 1'b1;
          if (post_clip && op2 != OP_NOP && op2 != OP_XY0 && op2 != OP_XY1) begin
            sat <= 1'b1;
          end
          case (op2)
            OP_FX:   px <= post_val;
            OP_FY:   py <= post_val;
            OP_FZ:   pz <= post_val;
            default: ;
          endcase
          if (count == LAST_CNT) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!rvalid || result.ready) begin
            rx     <= px;
            ry     <= py;
            rz     <= pz;
            rsat   <= sat;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
